// ----- rtl/rpn_stack_calculator_top_macros.svh -----
// assertion macros for the rpn stack calculator checker
// no dependencies, included by the checker file only
`ifndef RPN_STACK_CALCULATOR_TOP_MACROS_SVH
`define RPN_STACK_CALCULATOR_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define RPN_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define RPN_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/rpncalc_pkg.sv -----
// shared types and constants of the rpn stack calculator
// no dependencies, imported by rpncalc_ctrl, rpncalc_datapath and rpn_stack_calculator_top
`default_nettype none

package rpncalc_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int FRAC_BITS_DEF   = 16;

   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int DEPTH_W  = 5;
   localparam int STATUS_W = 3;

   localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;

   // opcodes six and seven carry no meaning and do nothing
   typedef enum logic [OP_W-1:0] {
      OP_PUSH = 3'd0,
      OP_POP  = 3'd1,
      OP_ADD  = 3'd2,
      OP_SUB  = 3'd3,
      OP_MUL  = 3'd4,
      OP_DIV  = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_UNDER   = 3'd1,
      ST_FULL    = 3'd2,
      ST_DIVZERO = 3'd3,
      ST_SAT     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CM_NONE,
      CM_PUSH,
      CM_POP,
      CM_BIN
   } commit_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_OPER,
      S_MUL,
      S_DIV,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic       latch_req;
      logic       rd_en;
      logic       load_a;
      logic       mul_en;
      logic       div_load;
      logic       div_step;
      logic       commit;
      commit_type commit_kind;
      status_type err_status;
   } ctrl_cmd_type;

   typedef struct packed {
      op_type op;
      logic   empty;
      logic   full;
      logic   lt2;
      logic   b_zero;
      logic   div_done;
      logic   out_free;
   } dp_status_type;

   typedef struct packed {
      logic [VALUE_W-1:0] val;
      logic               sat;
   } sat_res_type;

endpackage

`default_nettype wire

// ----- rtl/rpncalc_ram.sv -----
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none

module rpncalc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/rpncalc_datapath.sv -----
// datapath: operand registers, stack ram, adder, multiplier, divider, result register
// depends on rpncalc_pkg and rpncalc_ram
`default_nettype none

module rpncalc_datapath import rpncalc_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [OP_W-1:0]     req_op,
   input  wire logic [VALUE_W-1:0]  req_value,
   input  wire ctrl_cmd_type        cmd,
   output dp_status_type            sts,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [VALUE_W-1:0]       rsp_top_value,
   output logic                     rsp_top_valid,
   output logic [DEPTH_W-1:0]       rsp_depth,
   output logic [STATUS_W-1:0]      rsp_status
);

   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
   localparam int AW     = $clog2(STACK_DEPTH);
   localparam int DVD_W  = VALUE_W + FRAC_BITS;
   localparam int DCNT_W = $clog2(DVD_W + 1);
   localparam int PROD_W = 2 * VALUE_W;

   function automatic logic [VALUE_W-1:0] fx_mag(input logic [VALUE_W-1:0] v);
      fx_mag = v[VALUE_W-1] ? (~v + VALUE_W'(1)) : v;
   endfunction

   // apply sign to a magnitude and clamp to the 32-bit range
   function automatic sat_res_type fx_sat(input logic [PROD_W-1:0] q, input logic neg);
      sat_res_type r;
      logic [PROD_W-1:0] nq;
      nq = ~q + PROD_W'(1);
      r.sat = 1'b0;
      if (neg) begin
         if (q > PROD_W'(VAL_MIN)) begin
            r.val = VAL_MIN;
            r.sat = 1'b1;
         end else begin
            r.val = nq[VALUE_W-1:0];
         end
      end else begin
         if (q > PROD_W'(VAL_MAX)) begin
            r.val = VAL_MAX;
            r.sat = 1'b1;
         end else begin
            r.val = q[VALUE_W-1:0];
         end
      end
      fx_sat = r;
   endfunction

   op_type             op_ff, op_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [VALUE_W-1:0] top_ff, top_in;
   logic [VALUE_W-1:0] a_ff, a_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [DVD_W-1:0]   dvd_ff, dvd_in;
   logic [VALUE_W-1:0] rem_ff, rem_in;
   logic [VALUE_W-1:0] dvs_ff, dvs_in;
   logic [DCNT_W-1:0]  dcnt_ff, dcnt_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_top_value_ff, rsp_top_value_in;
   logic                rsp_top_valid_ff, rsp_top_valid_in;
   logic [DEPTH_W-1:0]  rsp_depth_ff, rsp_depth_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic [VALUE_W-1:0] rd_data;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic [CNT_W-1:0]   cnt_m2;
   logic [AW-1:0]      addr_second;
   logic [AW-1:0]      addr_push;

   logic [VALUE_W:0]   sum_ext;
   logic [VALUE_W:0]   diff_ext;
   logic [VALUE_W:0]   trial;
   logic [VALUE_W:0]   trial_sub;
   logic               trial_ge;
   logic               res_neg;
   sat_res_type        mul_res;
   sat_res_type        div_res;
   sat_res_type        bin_res;
   logic [31:0]        depth_ext;

   assign cnt_m2      = count_ff - CNT_W'(2);
   assign addr_second = cnt_m2[AW-1:0];
   assign addr_push   = count_ff[AW-1:0];

   rpncalc_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (addr_second),
      .rd_data (rd_data)
   );

   // operand capture, multiplier and radix-2 restoring divider
   always_comb begin
      op_in    = op_ff;
      value_in = value_ff;
      a_in     = a_ff;
      prod_in  = prod_ff;
      dvd_in   = dvd_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      dcnt_in  = dcnt_ff;

      trial     = {rem_ff, dvd_ff[DVD_W-1]};
      trial_sub = trial - {1'b0, dvs_ff};
      trial_ge  = trial >= {1'b0, dvs_ff};

      if (cmd.latch_req) begin
         op_in    = op_type'(req_op);
         value_in = req_value;
      end
      if (cmd.load_a) begin
         a_in = rd_data;
      end
      if (cmd.mul_en) begin
         prod_in = PROD_W'(fx_mag(a_ff)) * PROD_W'(fx_mag(top_ff));
      end
      if (cmd.div_load) begin
         dvd_in  = DVD_W'(fx_mag(rd_data)) << FRAC_BITS;
         dvs_in  = fx_mag(top_ff);
         rem_in  = '0;
         dcnt_in = DCNT_W'(DVD_W);
      end else if (cmd.div_step) begin
         rem_in  = trial_ge ? trial_sub[VALUE_W-1:0] : trial[VALUE_W-1:0];
         dvd_in  = {dvd_ff[DVD_W-2:0], trial_ge};
         dcnt_in = dcnt_ff - DCNT_W'(1);
      end
   end

   // binary result selection with saturation
   always_comb begin
      res_neg  = a_ff[VALUE_W-1] ^ top_ff[VALUE_W-1];
      sum_ext  = {a_ff[VALUE_W-1], a_ff} + {top_ff[VALUE_W-1], top_ff};
      diff_ext = {a_ff[VALUE_W-1], a_ff} - {top_ff[VALUE_W-1], top_ff};
      mul_res  = fx_sat(prod_ff >> FRAC_BITS, res_neg);
      div_res  = fx_sat(PROD_W'(dvd_ff), res_neg);
      case (op_ff)
         OP_ADD: begin
            bin_res.sat = sum_ext[VALUE_W] ^ sum_ext[VALUE_W-1];
            bin_res.val = bin_res.sat ? (sum_ext[VALUE_W] ? VAL_MIN : VAL_MAX)
                                      : sum_ext[VALUE_W-1:0];
         end
         OP_SUB: begin
            bin_res.sat = diff_ext[VALUE_W] ^ diff_ext[VALUE_W-1];
            bin_res.val = bin_res.sat ? (diff_ext[VALUE_W] ? VAL_MIN : VAL_MAX)
                                      : diff_ext[VALUE_W-1:0];
         end
         OP_MUL:  bin_res = mul_res;
         OP_DIV:  bin_res = div_res;
         default: bin_res = mul_res;
      endcase
   end

   // stack update and result register
   always_comb begin
      count_in = count_ff;
      top_in   = top_ff;
      wr_en    = 1'b0;
      wr_addr  = addr_push;
      wr_data  = value_ff;
      if (cmd.commit) begin
         case (cmd.commit_kind)
            CM_PUSH: begin
               wr_en    = 1'b1;
               top_in   = value_ff;
               count_in = count_ff + CNT_W'(1);
            end
            CM_POP: begin
               top_in   = rd_data;
               count_in = count_ff - CNT_W'(1);
            end
            CM_BIN: begin
               wr_en    = 1'b1;
               wr_addr  = addr_second;
               wr_data  = bin_res.val;
               top_in   = bin_res.val;
               count_in = count_ff - CNT_W'(1);
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end

      depth_ext        = 32'(count_in);
      rsp_valid_in     = cmd.commit | (rsp_valid_ff & ~rsp_ready);
      rsp_top_value_in = rsp_top_value_ff;
      rsp_top_valid_in = rsp_top_valid_ff;
      rsp_depth_in     = rsp_depth_ff;
      rsp_status_in    = rsp_status_ff;
      if (cmd.commit) begin
         rsp_top_valid_in = count_in != '0;
         rsp_top_value_in = (count_in != '0) ? top_in : '0;
         rsp_depth_in     = depth_ext[DEPTH_W-1:0];
         rsp_status_in    = ((cmd.commit_kind == CM_BIN) && bin_res.sat) ? ST_SAT
                                                                        : cmd.err_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff            <= op_in;
      value_ff         <= value_in;
      top_ff           <= top_in;
      a_ff             <= a_in;
      prod_ff          <= prod_in;
      dvd_ff           <= dvd_in;
      rem_ff           <= rem_in;
      dvs_ff           <= dvs_in;
      dcnt_ff          <= dcnt_in;
      rsp_top_value_ff <= rsp_top_value_in;
      rsp_top_valid_ff <= rsp_top_valid_in;
      rsp_depth_ff     <= rsp_depth_in;
      rsp_status_ff    <= rsp_status_in;
   end

   always_comb begin
      sts.op       = op_ff;
      sts.empty    = count_ff == '0;
      sts.full     = count_ff == CNT_W'(STACK_DEPTH);
      sts.lt2      = count_ff < CNT_W'(2);
      sts.b_zero   = top_ff == '0;
      sts.div_done = dcnt_ff == '0;
      sts.out_free = ~rsp_valid_ff | rsp_ready;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_top_value = rsp_top_value_ff;
   assign rsp_top_valid = rsp_top_valid_ff;
   assign rsp_depth     = rsp_depth_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

`default_nettype wire

// ----- rtl/rpncalc_ctrl.sv -----
// controller state machine: sequences decode, operand fetch, arithmetic and commit
// depends on rpncalc_pkg
`default_nettype none

module rpncalc_ctrl import rpncalc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type sts,
   output ctrl_cmd_type       cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.op)
               OP_ADD, OP_SUB, OP_MUL: begin
                  state_in = sts.lt2 ? S_FINISH : S_OPER;
               end
               OP_DIV: begin
                  state_in = (sts.lt2 || sts.b_zero) ? S_FINISH : S_OPER;
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_OPER: begin
            case (sts.op)
               OP_MUL:  state_in = S_MUL;
               OP_DIV:  state_in = S_DIV;
               default: state_in = S_FINISH;
            endcase
         end
         S_MUL: state_in = S_FINISH;
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready       = 1'b0;
      cmd.latch_req   = 1'b0;
      cmd.rd_en       = 1'b0;
      cmd.load_a      = 1'b0;
      cmd.mul_en      = 1'b0;
      cmd.div_load    = 1'b0;
      cmd.div_step    = 1'b0;
      cmd.commit      = 1'b0;
      cmd.commit_kind = CM_NONE;
      cmd.err_status  = ST_OK;
      case (state_ff)
         S_IDLE: begin
            req_ready     = 1'b1;
            cmd.latch_req = req_valid;
         end
         S_DECODE: begin
            // second entry, which is also the new top after a pop
            cmd.rd_en = ~sts.lt2;
         end
         S_OPER: begin
            cmd.load_a   = 1'b1;
            cmd.div_load = sts.op == OP_DIV;
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
         end
         S_DIV: begin
            cmd.div_step = ~sts.div_done;
         end
         S_FINISH: begin
            cmd.commit = sts.out_free;
            case (sts.op)
               OP_PUSH: begin
                  cmd.commit_kind = sts.full ? CM_NONE : CM_PUSH;
                  cmd.err_status  = sts.full ? ST_FULL : ST_OK;
               end
               OP_POP: begin
                  cmd.commit_kind = sts.empty ? CM_NONE : CM_POP;
                  cmd.err_status  = sts.empty ? ST_UNDER : ST_OK;
               end
               OP_ADD, OP_SUB, OP_MUL: begin
                  cmd.commit_kind = sts.lt2 ? CM_NONE : CM_BIN;
                  cmd.err_status  = sts.lt2 ? ST_UNDER : ST_OK;
               end
               OP_DIV: begin
                  if (sts.lt2) begin
                     cmd.err_status = ST_UNDER;
                  end else if (sts.b_zero) begin
                     cmd.err_status = ST_DIVZERO;
                  end else begin
                     cmd.commit_kind = CM_BIN;
                  end
               end
               default: cmd.commit_kind = CM_NONE;
            endcase
         end
         default: req_ready = 1'b0;
      endcase
   end

endmodule

`default_nettype wire

// ----- rtl/rpn_stack_calculator_top.sv -----
// rpn stack calculator top level: controller plus datapath
// depends on rpncalc_pkg, rpncalc_ctrl, rpncalc_datapath, rpncalc_ram
//
// usage
// - req channel: one transaction carries an opcode (push, pop, add, sub, mul, div;
//   codes six and seven do nothing) and a signed q16.16 value used by push
// - rsp channel: one transaction per request with the new top of stack (zero when
//   empty), a valid flag for it, the stack depth and a status code
// - binary operations pop b then a and push a op b; add and sub saturate, mul and
//   div truncate toward zero and saturate; underflow, full stack and divide by
//   zero leave the stack as it was
// - one request is worked at a time; push, pop and ignored codes pass decode and
//   finish; add and sub add an operand state; mul adds that and a multiply state,
//   div that and the radix-2 divider that retires one quotient bit per cycle
// - the result appears in the rsp register in the same cycle as req_ready returns
// - the second stack entry is fetched from the stack ram, the top sits in a register
// - a stalled receiver holds the result in the output register; a new request is
//   still taken and worked, and its commit waits until the register frees up
// - reset empties the stack at once; the ram needs no clearing since only entries
//   below the depth count are ever read
`default_nettype none

module rpn_stack_calculator_top import rpncalc_pkg::*; #(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic        [OP_W-1:0]     req_op,
   input  wire logic signed [VALUE_W-1:0]  req_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic signed      [VALUE_W-1:0]  rsp_top_value,
   output logic                            rsp_top_valid,
   output logic             [DEPTH_W-1:0]  rsp_depth,
   output logic             [STATUS_W-1:0] rsp_status
);

   ctrl_cmd_type       cmd;
   dp_status_type      sts;
   logic [VALUE_W-1:0] top_value;

   // sequencing of each transaction
   rpncalc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // stack storage, arithmetic and the output register
   rpncalc_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_op        (req_op),
      .req_value     (req_value),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_top_value (top_value),
      .rsp_top_valid (rsp_top_valid),
      .rsp_depth     (rsp_depth),
      .rsp_status    (rsp_status)
   );

   assign rsp_top_value = top_value;

endmodule

`default_nettype wire

// ----- rtl/rpncalc_checker.sv -----
// port level checks of the rpn stack calculator, bound to the top level
// depends on rpn_stack_calculator_top_macros.svh
`default_nettype none
`include "rpn_stack_calculator_top_macros.svh"

module rpncalc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_top_value,
   input wire logic        rsp_top_valid,
   input wire logic [4:0]  rsp_depth,
   input wire logic [2:0]  rsp_status
);

   // a stalled result stays put
   `RPN_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_top_value) && $stable(rsp_depth) && $stable(rsp_status), "stalled result changed")

   // one transaction at a time: ready drops right after an accept
   `RPN_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "second request taken while busy")

   // top valid tracks a nonempty stack
   `RPN_ASSERT_SAME(a_top_valid, clock, reset, rsp_valid, rsp_top_valid == (rsp_depth != 5'd0), "top valid disagrees with depth")

   // empty stack reports a zero top
   `RPN_ASSERT_SAME(a_empty_zero, clock, reset, rsp_valid && !rsp_top_valid, rsp_top_value == 32'd0, "empty stack with nonzero top")

endmodule

bind rpn_stack_calculator_top rpncalc_checker u_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_top_value (rsp_top_value),
   .rsp_top_valid (rsp_top_valid),
   .rsp_depth     (rsp_depth),
   .rsp_status    (rsp_status)
);

`default_nettype wire

// ----- verif/rpn_stack_calculator_checker.sv -----
// transaction checker for the rpn stack calculator: predicts each response
// from the accepted requests and compares it field by field
// depends on rpncalc_pkg only
`timescale 1ns / 100ps

module rpn_stack_calculator_checker
   import rpncalc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [OP_W-1:0]     req_op,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [VALUE_W-1:0]  rsp_top_value,
   input  logic                rsp_top_valid,
   input  logic [DEPTH_W-1:0]  rsp_depth,
   input  logic [STATUS_W-1:0] rsp_status,
   output int unsigned         fail_count,
   output int unsigned         pending_count
);

   typedef struct packed {
      logic [VALUE_W-1:0]  top_value;
      logic                top_valid;
      logic [DEPTH_W-1:0]  depth;
      logic [STATUS_W-1:0] status;
   } stack_view_t;

   localparam logic signed [63:0] WIDE_MAX = 64'sd2147483647;
   localparam logic signed [63:0] WIDE_MIN = -64'sd2147483648;

   logic [VALUE_W-1:0] shadow_stack [STACK_DEPTH_DEF];
   int unsigned        shadow_depth;
   stack_view_t        expected_views [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      shadow_depth  = 0;
   end

   function automatic logic [63:0] magnitude(input logic signed [VALUE_W-1:0] v);
      logic signed [63:0] wide;
      wide = v;
      return (wide < 0) ? 64'(-wide) : 64'(wide);
   endfunction

   // apply the sign to a magnitude and clamp it to 32 bits
   function automatic logic [VALUE_W-1:0] sign_and_clamp(input logic [63:0] q,
                                                         input logic neg,
                                                         output logic sat);
      logic [63:0] negated;
      sat = 1'b0;
      negated = -q;
      if (neg) begin
         if (q > 64'h8000_0000) begin
            sat = 1'b1;
            return VAL_MIN;
         end
         return negated[VALUE_W-1:0];
      end
      if (q > 64'h7FFF_FFFF) begin
         sat = 1'b1;
         return VAL_MAX;
      end
      return q[VALUE_W-1:0];
   endfunction

   function automatic logic [VALUE_W-1:0] clamp_wide(input logic signed [63:0] v,
                                                     output logic sat);
      sat = 1'b0;
      if (v > WIDE_MAX) begin
         sat = 1'b1;
         return VAL_MAX;
      end
      if (v < WIDE_MIN) begin
         sat = 1'b1;
         return VAL_MIN;
      end
      return v[VALUE_W-1:0];
   endfunction

   // updates the shadow stack and returns the response the step must produce
   function automatic stack_view_t apply_request(input logic [OP_W-1:0] op,
                                                 input logic [VALUE_W-1:0] value);
      logic signed [VALUE_W-1:0] a, b;
      logic signed [63:0]        wide_a, wide_b;
      logic [VALUE_W-1:0]        res;
      logic                      sat, by_zero, neg;
      status_type                st;
      stack_view_t               view;
      st      = ST_OK;
      sat     = 1'b0;
      by_zero = 1'b0;
      res     = '0;
      case (op)
         OP_PUSH: begin
            if (shadow_depth >= STACK_DEPTH_DEF) begin
               st = ST_FULL;
            end else begin
               shadow_stack[shadow_depth] = value;
               shadow_depth++;
            end
         end
         OP_POP: begin
            if (shadow_depth == 0) st = ST_UNDER;
            else shadow_depth--;
         end
         OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
            if (shadow_depth < 2) begin
               st = ST_UNDER;
            end else begin
               b      = shadow_stack[shadow_depth-1];
               a      = shadow_stack[shadow_depth-2];
               wide_a = a;
               wide_b = b;
               neg    = a[VALUE_W-1] ^ b[VALUE_W-1];
               case (op)
                  OP_ADD: res = clamp_wide(wide_a + wide_b, sat);
                  OP_SUB: res = clamp_wide(wide_a - wide_b, sat);
                  OP_MUL: res = sign_and_clamp((magnitude(a) * magnitude(b)) >> FRAC_BITS_DEF,
                                               neg, sat);
                  default: begin
                     if (b == 0) by_zero = 1'b1;
                     else res = sign_and_clamp((magnitude(a) << FRAC_BITS_DEF) / magnitude(b),
                                               neg, sat);
                  end
               endcase
               if (by_zero) begin
                  st = ST_DIVZERO;
               end else begin
                  shadow_depth--;
                  shadow_stack[shadow_depth-1] = res;
                  if (sat) st = ST_SAT;
               end
            end
         end
         default: ;
      endcase
      view.top_valid = (shadow_depth != 0);
      view.top_value = (shadow_depth != 0) ? shadow_stack[shadow_depth-1] : '0;
      view.depth     = DEPTH_W'(shadow_depth);
      view.status    = st;
      return view;
   endfunction

   task automatic compare_field(input string label, input logic [VALUE_W-1:0] want,
                                input logic [VALUE_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      stack_view_t want;
      if (reset) begin
         shadow_depth = 0;
         expected_views.delete();
      end else begin
         if (req_valid && req_ready) expected_views.push_back(apply_request(req_op, req_value));
         if (rsp_valid && rsp_ready) begin
            if (expected_views.size() == 0) begin
               $display("%0t: response with none pending, actual top %h depth %0d status %0d",
                        $time, rsp_top_value, rsp_depth, rsp_status);
               fail_count++;
            end else begin
               want = expected_views.pop_front();
               compare_field("top_value", want.top_value, rsp_top_value);
               compare_field("top_valid", VALUE_W'(want.top_valid), VALUE_W'(rsp_top_valid));
               compare_field("depth", VALUE_W'(want.depth), VALUE_W'(rsp_depth));
               compare_field("status", VALUE_W'(want.status), VALUE_W'(rsp_status));
            end
         end
      end
      pending_count = expected_views.size();
   end

endmodule

// ----- verif/tb_rpn_stack_calculator_top.sv -----
// testbench top for the rpn stack calculator: drives requests and response
// backpressure, the checker module predicts and compares
// depends on rpncalc_pkg, rpn_stack_calculator_top, rpn_stack_calculator_checker
`timescale 1ns / 100ps

module tb_rpn_stack_calculator_top;
   import rpncalc_pkg::*;

   // opcodes the block ignores
   localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

   // notable q16.16 operands
   localparam logic [VALUE_W-1:0] ZERO_VAL       = 32'h0000_0000;
   localparam logic [VALUE_W-1:0] ONE_LSB        = 32'h0000_0001;
   localparam logic [VALUE_W-1:0] MINUS_LSB      = 32'hFFFF_FFFF;
   localparam logic [VALUE_W-1:0] ONE_UNIT       = 32'h0001_0000;
   localparam logic [VALUE_W-1:0] MINUS_ONE_UNIT = 32'hFFFF_0000;

   localparam int unsigned RANDOM_ITEMS = 800;
   // well beyond a div plus the longest gaps and stalls that the bench draws
   localparam int unsigned IDLE_LIMIT   = 3000;
   localparam int unsigned DRAIN_CYCLES = 60;

   logic                clock;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_op    = '0;
   logic [VALUE_W-1:0]  req_value = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [VALUE_W-1:0]  rsp_top_value;
   logic                rsp_top_valid;
   logic [DEPTH_W-1:0]  rsp_depth;
   logic [STATUS_W-1:0] rsp_status;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned idle_cycles = 0;
   // set for whole bursts so that long stretches run with no gaps at all
   bit          steady_run  = 1'b0;

   rpn_stack_calculator_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_top_value (rsp_top_value),
      .rsp_top_valid (rsp_top_valid),
      .rsp_depth     (rsp_depth),
      .rsp_status    (rsp_status)
   );

   rpn_stack_calculator_checker result_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_top_value (rsp_top_value),
      .rsp_top_valid (rsp_top_valid),
      .rsp_depth     (rsp_depth),
      .rsp_status    (rsp_status),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // idle length: mostly none, some short, a few long; none during steady bursts
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (steady_run) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // operand mix: extremes, small q16.16 numbers with random fractions, raw bits
   function automatic logic [VALUE_W-1:0] random_value();
      int unsigned roll;
      int          whole;
      roll = $urandom_range(0, 9);
      if (roll < 2) begin
         case ($urandom_range(0, 6))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return ZERO_VAL;
            3:       return ONE_LSB;
            4:       return MINUS_LSB;
            5:       return ONE_UNIT;
            default: return MINUS_ONE_UNIT;
         endcase
      end
      if (roll < 6) begin
         whole = int'($urandom_range(0, 32)) - 16;
         return VALUE_W'((whole <<< FRAC_BITS_DEF) + int'($urandom_range(0, 65535)));
      end
      return $urandom();
   endfunction

   // fill bursts push hard to reach a full stack, drain bursts pop and operate
   // until underflow, balanced bursts keep the arithmetic busy at mid depth
   function automatic logic [OP_W-1:0] pick_op(input int unsigned mode);
      int unsigned roll;
      int unsigned push_cut, pop_cut;
      roll = $urandom_range(0, 99);
      if (roll < 4) return ($urandom_range(0, 1) != 0) ? OP_SPARE_HI : OP_SPARE_LO;
      case (mode)
         0:       begin push_cut = 45; pop_cut = 55; end
         1:       begin push_cut = 80; pop_cut = 84; end
         default: begin push_cut = 20; pop_cut = 45; end
      endcase
      if (roll < push_cut) return OP_PUSH;
      if (roll < pop_cut) return OP_POP;
      return OP_W'($urandom_range(OP_ADD, OP_DIV));
   endfunction

   // one request transaction; entered and left at a falling edge with valid held
   task automatic send(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // response backpressure
   initial begin
      int unsigned hold;
      @(negedge clock);
      forever begin
         hold = pick_gap();
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   end

   // watchdog: too long with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("tb_rpn_stack_calculator_top failed");
            $finish;
         end
      end
   end

   initial begin
      int unsigned counted;
      int unsigned burst_left;
      int unsigned mode;
      logic [OP_W-1:0] op;
      counted    = 0;
      burst_left = 0;
      mode       = 0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty stack: pop and binary op underflow, spare opcodes do nothing
      send(OP_POP, ZERO_VAL);
      send(OP_ADD, VAL_MAX);
      send(OP_SPARE_LO, VAL_MIN);
      send(OP_SPARE_HI, MINUS_LSB);
      // max + lsb clamps positive
      send(OP_PUSH, VAL_MAX);
      send(OP_PUSH, ONE_LSB);
      send(OP_ADD, ZERO_VAL);
      // max - min clamps positive
      send(OP_PUSH, VAL_MIN);
      send(OP_SUB, ZERO_VAL);
      // divide by zero leaves both operands, then drop the zero
      send(OP_PUSH, ZERO_VAL);
      send(OP_DIV, ZERO_VAL);
      send(OP_POP, ZERO_VAL);
      // max * min clamps negative
      send(OP_PUSH, VAL_MIN);
      send(OP_MUL, ZERO_VAL);
      // min * min clamps positive
      send(OP_PUSH, VAL_MIN);
      send(OP_MUL, ZERO_VAL);
      // max / -lsb clamps negative
      send(OP_PUSH, MINUS_LSB);
      send(OP_DIV, ZERO_VAL);
      // min / -1.0 lands one past max and clamps
      send(OP_PUSH, MINUS_ONE_UNIT);
      send(OP_DIV, ZERO_VAL);
      send(OP_POP, ZERO_VAL);

      // random bursts; a full stack comes from the fill bursts
      while (counted < RANDOM_ITEMS) begin
         if (burst_left == 0) begin
            mode       = $urandom_range(0, 2);
            burst_left = $urandom_range(15, 40);
            steady_run = ($urandom_range(0, 4) == 0);
         end
         op = pick_op(mode);
         send(op, random_value());
         if (op <= OP_DIV) counted++;
         burst_left--;
      end
      steady_run = 1'b0;
      req_valid <= 1'b0;

      // drain the outstanding responses, then watch for strays
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("tb_rpn_stack_calculator_top passed");
      end else begin
         $display("tb_rpn_stack_calculator_top failed");
      end
      $finish;
   end

endmodule
